/* hw/rtl/uaf_pkg.sv */
package uaf_pkg;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	localparam logic [7:0] ASCII_LIMIT = 8'h80;
	localparam logic [7:0] LEAD_C3_BYTE = 8'hC3;
	localparam logic [7:0] LEAD_C5_BYTE = 8'hC5;
	localparam logic [7:0] OE_UPPER = 8'h92;
	localparam logic [7:0] OE_LOWER = 8'h93;
	localparam logic [7:0] Y_DIAERESIS = 8'hBF;
	localparam logic [7:0] CHAR_UPPER_A = 8'h41;
	localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
	localparam logic [7:0] CASE_OFFSET = 8'h20;
	localparam logic [7:0] CHAR_A = 8'h61;
	localparam logic [7:0] CHAR_C = 8'h63;
	localparam logic [7:0] CHAR_E = 8'h65;
	localparam logic [7:0] CHAR_I = 8'h69;
	localparam logic [7:0] CHAR_O = 8'h6F;
	localparam logic [7:0] CHAR_U = 8'h75;
	localparam logic [7:0] CHAR_Y = 8'h79;
	localparam logic [7:0] NO_FOLD = 8'h00;

	typedef enum logic [2:0] {
		LEAD_NONE = 3'b001,
		LEAD_C3   = 3'b010,
		LEAD_C5   = 3'b100
	} lead_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} fword_t;

	typedef struct packed {
		logic [1:0] n;
		fword_t     w0;
		fword_t     w1;
	} fpush_t;

	typedef struct packed {
		logic             room;
		logic [FIFO_AW:0] count;
	} fstat_t;

	function automatic logic in_rng(input logic [7:0] v, input logic [7:0] lo,
		input logic [7:0] hi);
		return (v >= lo) && (v <= hi);
	endfunction

	function automatic logic [7:0] fold_c3(input logic [7:0] n);
		logic [7:0] f;
		f = NO_FOLD;
		priority if (in_rng(n, 8'h80, 8'h85) || in_rng(n, 8'hA0, 8'hA5)) begin
			f = CHAR_A;
		end else if (n == 8'h87 || n == 8'hA7) begin
			f = CHAR_C;
		end else if (in_rng(n, 8'h88, 8'h8B) || in_rng(n, 8'hA8, 8'hAB)) begin
			f = CHAR_E;
		end else if (in_rng(n, 8'h8C, 8'h8F) || in_rng(n, 8'hAC, 8'hAF)) begin
			f = CHAR_I;
		end else if (in_rng(n, 8'h92, 8'h96) || in_rng(n, 8'hB2, 8'hB6)) begin
			f = CHAR_O;
		end else if (in_rng(n, 8'h99, 8'h9C) || in_rng(n, 8'hB9, 8'hBC)) begin
			f = CHAR_U;
		end else if (n == 8'h9D || n == 8'hBD || n == Y_DIAERESIS) begin
			f = CHAR_Y;
		end else begin
			f = NO_FOLD;
		end
		return f;
	endfunction

endpackage

/* hw/rtl/uaf_out_fifo.sv */
module uaf_out_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  uaf_pkg::fpush_t push,
	output uaf_pkg::fword_t head,
	output logic            head_valid,
	input  logic            pop,
	output uaf_pkg::fstat_t stat
);
	import uaf_pkg::*;

	fword_t             mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [FIFO_AW:0]   cnt_q;
	logic [FIFO_AW-1:0] wr_next;
	logic               do_pop;

	assign wr_next    = wr_ptr_q + FIFO_AW'(1);
	assign head_valid = (cnt_q != '0);
	assign head       = mem_q[rd_ptr_q];
	assign do_pop     = pop && head_valid;
	assign stat       = '{room: (cnt_q <= (FIFO_AW+1)'(FIFO_DEPTH - 2)), count: cnt_q};

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			mem_q[wr_ptr_q] <= push.w0;
		end
		if (push.n == 2'd2) begin
			mem_q[wr_next] <= push.w1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + FIFO_AW'(push.n);
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			end
			cnt_q <= cnt_q + (FIFO_AW+1)'(push.n) - (FIFO_AW+1)'(do_pop);
		end
	end

endmodule

/* hw/rtl/utf8_accent_folder.sv */
// The folded words of an accepted byte are registered in the output queue before they reach the outputs.
// Throughput: one byte per cycle; pairs that give two words drain at one
// word per cycle while result_ready is high from a four-entry output queue, which may stall the input.
// Reset (arst_n low, asynchronous): no lead byte held, output queue empty.
module utf8_accent_folder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_ready,
	input  logic [7:0] byte_in,
	input  logic       word_end,
	output logic       result_valid,
	input  logic       result_ready,
	output logic [7:0] byte_out,
	output logic       folded_end
);
	import uaf_pkg::*;

	lead_t      lead_q;
	lead_t      lead_next;
	fpush_t     push;
	fpush_t     decode;
	fword_t     head;
	fstat_t     stat;
	logic       accept;
	logic [7:0] fold;
	logic       is_oe;

	assign item_ready = stat.room;
	assign accept     = item_valid && item_ready;
	assign fold       = fold_c3(byte_in);
	assign is_oe      = (byte_in == OE_UPPER) || (byte_in == OE_LOWER);

	always_comb begin
		decode    = '0;
		lead_next = LEAD_NONE;
		unique case (lead_q)
			LEAD_C3: begin
				if (fold != NO_FOLD) begin
					decode.n  = 2'd1;
					decode.w0 = '{data: fold, last: word_end};
				end else begin
					decode.n  = 2'd2;
					decode.w0 = '{data: LEAD_C3_BYTE, last: 1'b0};
					decode.w1 = '{data: byte_in, last: word_end};
				end
			end
			LEAD_C5: begin
				decode.n  = 2'd2;
				decode.w0 = '{data: (is_oe ? CHAR_O : LEAD_C5_BYTE), last: 1'b0};
				decode.w1 = '{data: (is_oe ? CHAR_E : byte_in), last: word_end};
			end
			default: begin
				decode.n  = 2'd1;
				decode.w0 = '{data: byte_in, last: word_end};
				priority if (byte_in < ASCII_LIMIT) begin
					if (byte_in >= CHAR_UPPER_A && byte_in <= CHAR_UPPER_Z) begin
						decode.w0.data = byte_in + CASE_OFFSET;
					end
				end else if (!word_end && byte_in == LEAD_C3_BYTE) begin
					decode.n  = 2'd0;
					lead_next = LEAD_C3;
				end else if (!word_end && byte_in == LEAD_C5_BYTE) begin
					decode.n  = 2'd0;
					lead_next = LEAD_C5;
				end else begin
					decode.n = 2'd1;
				end
			end
		endcase
	end

	always_comb begin
		push = decode;
		if (!accept) begin
			push.n = 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_q <= LEAD_NONE;
		end else if (accept) begin
			lead_q <= lead_next;
		end
	end

	uaf_out_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.head      (head),
		.head_valid(result_valid),
		.pop       (result_ready),
		.stat      (stat)
	);

	assign byte_out   = head.data;
	assign folded_end = head.last;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stat.count <= (FIFO_AW+1)'(FIFO_DEPTH))
		else $error("output queue overfilled");

	a_lead_held: assert property (@(posedge clk) disable iff (!arst_n)
		accept && lead_q == LEAD_NONE && !word_end && byte_in == LEAD_C3_BYTE
		|=> lead_q == LEAD_C3)
		else $error("lead byte not held");

	a_ascii_out: assert property (@(posedge clk) disable iff (!arst_n)
		accept && lead_q == LEAD_NONE && byte_in < ASCII_LIMIT
		|=> result_valid)
		else $error("ascii byte gave no word");

	a_pair_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && lead_q != LEAD_NONE |=> lead_q == LEAD_NONE)
		else $error("lead byte not released by pair");

endmodule
